// File: hw/rtl/sjiscsv_pkg.sv
// Package with shared types, byte codes and helpers for the Shift-JIS CSV record splitter.
`timescale 1ns / 1ps

package sjiscsv_pkg;

   // Field count limit and fixed field widths.
   localparam int unsigned MAX_FIELDS_DEFAULT = 255;
   localparam int unsigned BYTE_W             = 8;
   localparam int unsigned COUNT_W            = 8;

   // Byte codes the parser looks for.
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CHAR_QUOTE = 8'h22;
   localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;
   localparam logic [BYTE_W-1:0] LEAD1_LO   = 8'h80;
   localparam logic [BYTE_W-1:0] LEAD1_HI   = 8'h9F;
   localparam logic [BYTE_W-1:0] LEAD2_LO   = 8'hE0;

   // Parser mode, one-hot.
   typedef enum logic [3:0] {
      MODE_SKIP    = 4'b0001,
      MODE_PLAIN   = 4'b0010,
      MODE_QUOTED  = 4'b0100,
      MODE_DISCARD = 4'b1000
   } mode_type;

   // One result beat as it travels from the parser to the output register.
   typedef struct packed {
      logic               emit;
      logic [BYTE_W-1:0]  data_out;
      logic               data_valid;
      logic               field_end;
      logic [COUNT_W-1:0] field_index;
      logic               record_end;
      logic [COUNT_W-1:0] field_total;
   } result_type;

   // True for a Shift-JIS lead byte: 0x80-0x9F or 0xE0-0xFF.
   function automatic logic is_lead(input logic [BYTE_W-1:0] b);
      return ((b >= LEAD1_LO) && (b <= LEAD1_HI)) || (b >= LEAD2_LO);
   endfunction

endpackage

// File: hw/rtl/sjis_csv_record_splitter_top.sv
// Top level of the Shift-JIS CSV record splitter.
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_ready  data_in, record_last
//   rsp      out        rsp_valid/rsp_ready  data_out, data_valid, field_end,
//                                            field_index, record_end, field_total
//
// One byte is accepted per cycle while the result register can take a beat; its result beat
// appears in the result register on the next cycle, after the single parser step before
// that register. A byte that yields no beat only updates parser state.
// Synchronous active-high reset returns the parser to blank skipping with a zero
// field count and empties the result register. Input is taken while the result
// register is empty or being drained in the same cycle, so a stalled consumer
// stops the input after one held beat.
`timescale 1ns / 1ps

module sjis_csv_record_splitter_top
   import sjiscsv_pkg::*;
#(
   parameter int unsigned MAX_FIELDS = MAX_FIELDS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [BYTE_W-1:0]  req_data_in,
   input  logic               req_record_last,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [BYTE_W-1:0]  rsp_data_out,
   output logic               rsp_data_valid,
   output logic               rsp_field_end,
   output logic [COUNT_W-1:0] rsp_field_index,
   output logic               rsp_record_end,
   output logic [COUNT_W-1:0] rsp_field_total
);

   logic       accept;
   logic       hold_valid;
   result_type step_result;
   result_type hold_data;

   // Input is taken when the result stage can take a beat this cycle.
   assign req_ready = !hold_valid || rsp_ready;
   assign accept    = req_valid && req_ready;

   sjiscsv_parse #(
      .MAX_FIELDS (MAX_FIELDS)
   ) u_parse (
      .clock       (clock),
      .reset       (reset),
      .advance     (accept),
      .data_in     (req_data_in),
      .record_last (req_record_last),
      .result      (step_result)
   );

   sjiscsv_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (accept && step_result.emit),
      .load_data  (step_result),
      .take       (rsp_ready),
      .hold_valid (hold_valid),
      .hold_data  (hold_data)
   );

   // Result ports.
   assign rsp_valid       = hold_valid;
   assign rsp_data_out    = hold_data.data_out;
   assign rsp_data_valid  = hold_data.data_valid;
   assign rsp_field_end   = hold_data.field_end;
   assign rsp_field_index = hold_data.field_index;
   assign rsp_record_end  = hold_data.record_end;
   assign rsp_field_total = hold_data.field_total;

endmodule

// File: hw/rtl/sjiscsv_parse.sv
// Per-byte parser: mode, trail flag and field counter, with the result for each byte.
`timescale 1ns / 1ps

module sjiscsv_parse
   import sjiscsv_pkg::*;
#(
   parameter int unsigned MAX_FIELDS = MAX_FIELDS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic [BYTE_W-1:0]  data_in,
   input  logic               record_last,
   output result_type         result
);

   localparam logic [COUNT_W-1:0] MaxCount = COUNT_W'(MAX_FIELDS);

   mode_type           mode_ff, mode_in;
   logic               trail_ff, trail_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic               valid;
   logic               fend;
   logic               bump;
   logic               lead;
   mode_type           mode_nx;

   assign lead = is_lead(data_in);

   // Mode step for one byte.
   always_comb begin
      valid    = 1'b0;
      fend     = 1'b0;
      trail_in = 1'b0;
      mode_nx  = mode_ff;
      if (trail_ff) begin
         valid = (mode_ff == MODE_PLAIN) || (mode_ff == MODE_QUOTED);
      end else begin
         unique case (mode_ff)
            MODE_SKIP: begin
               if (lead) begin
                  valid    = 1'b1;
                  trail_in = 1'b1;
                  mode_nx  = MODE_PLAIN;
               end else if ((data_in == CHAR_SPACE) || (data_in == CHAR_TAB)) begin
                  mode_nx = MODE_SKIP;
               end else if (data_in == CHAR_QUOTE) begin
                  mode_nx = MODE_QUOTED;
               end else if (data_in == CHAR_COMMA) begin
                  fend = 1'b1;
               end else begin
                  valid   = 1'b1;
                  mode_nx = MODE_PLAIN;
               end
            end
            MODE_PLAIN: begin
               if (lead) begin
                  valid    = 1'b1;
                  trail_in = 1'b1;
               end else if (data_in == CHAR_COMMA) begin
                  fend    = 1'b1;
                  mode_nx = MODE_SKIP;
               end else begin
                  valid = 1'b1;
               end
            end
            MODE_QUOTED: begin
               if (lead) begin
                  valid    = 1'b1;
                  trail_in = 1'b1;
               end else if (data_in == CHAR_QUOTE) begin
                  mode_nx = MODE_DISCARD;
               end else begin
                  valid = 1'b1;
               end
            end
            MODE_DISCARD: begin
               if (lead) begin
                  trail_in = 1'b1;
               end else if (data_in == CHAR_COMMA) begin
                  fend    = 1'b1;
                  mode_nx = MODE_SKIP;
               end
            end
            default: begin
               mode_nx = MODE_SKIP;
            end
         endcase
      end
      // The last byte also closes a field that is still open.
      if (record_last && (mode_nx != MODE_SKIP)) begin
         fend = 1'b1;
      end
   end

   // A field is counted at most once per byte, saturating at the limit.
   assign bump     = fend && (count_ff < MaxCount);
   assign count_in = record_last ? '0 : (count_ff + COUNT_W'(bump));
   assign mode_in  = record_last ? MODE_SKIP : mode_nx;

   // Result beat for this byte.
   always_comb begin
      result.emit        = valid || fend || record_last;
      result.data_out    = valid ? data_in : '0;
      result.data_valid  = valid;
      result.field_end   = fend;
      result.field_index = count_ff;
      result.record_end  = record_last;
      result.field_total = count_ff + COUNT_W'(bump);
   end

   // State update on each accepted byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_SKIP;
         trail_ff <= 1'b0;
         count_ff <= '0;
      end else if (advance) begin
         mode_ff  <= mode_in;
         trail_ff <= record_last ? 1'b0 : trail_in;
         count_ff <= count_in;
      end
   end

endmodule

// File: hw/rtl/sjiscsv_out_reg.sv
// Result register that holds one beat until the consumer takes it.
`timescale 1ns / 1ps

module sjiscsv_out_reg
   import sjiscsv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type load_data,
   input  logic       take,
   output logic       hold_valid,
   output result_type hold_data
);

   logic       valid_ff, valid_in;
   result_type data_ff;

   // A new beat replaces the held one; otherwise a taken beat empties the stage.
   assign valid_in = load || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign hold_valid = valid_ff;
   assign hold_data  = data_ff;

endmodule

// File: hw/rtl/sjiscsv_checker.sv
// Port-level checker for the Shift-JIS CSV record splitter, bound to the top level.
`timescale 1ns / 1ps

module sjiscsv_checker
   import sjiscsv_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [BYTE_W-1:0]  rsp_data_out,
   input logic               rsp_data_valid,
   input logic               rsp_field_end,
   input logic [COUNT_W-1:0] rsp_field_index,
   input logic [COUNT_W-1:0] rsp_field_total
);

   // The result stage is empty right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat present after reset");

   // A beat without content carries a zero byte.
   a_zero_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data_valid) |-> (rsp_data_out == '0))
      else $error("content byte set on a beat without content");

   // The running total never falls behind the index of the current field.
   a_total_ge_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_field_total >= rsp_field_index))
      else $error("field total below field index");

   // A beat that closes a field reports a nonzero field total.
   a_end_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_field_end) |-> (rsp_field_total != '0))
      else $error("field end with zero field total");

   // A stalled beat stays in place.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data_out)
                                     && $stable(rsp_field_total)))
      else $error("result beat changed while stalled");

endmodule

bind sjis_csv_record_splitter_top sjiscsv_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_data_out    (rsp_data_out),
   .rsp_data_valid  (rsp_data_valid),
   .rsp_field_end   (rsp_field_end),
   .rsp_field_index (rsp_field_index),
   .rsp_field_total (rsp_field_total)
);
